// ----- rtl/pscz_pkg.sv -----
// ----------------------------------------------------------------------------
// pscz_pkg: shared types and constants for the pixel stretch and zoom block
// Holds the item payload types, the register map and the format codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pscz_pkg;

	// Default sizing of the top level.
	localparam int MAX_ZOOM_DEF  = 16;
	localparam int LINE_BITS_DEF = 16;

	// Depth of the queue between the front and the back part (power of two).
	localparam int QUEUE_DEPTH = 4;

	// Largest display byte.
	localparam logic [7:0] PIX_MAX = 8'd255;

	// Source element formats.
	localparam logic [1:0] FMT_U8  = 2'd0;
	localparam logic [1:0] FMT_S16 = 2'd1;
	localparam logic [1:0] FMT_S32 = 2'd2;

	// Register map of the configuration port.
	typedef enum logic [2:0] {
		REG_FORMAT       = 3'd0,
		REG_GAIN         = 3'd1,
		REG_BIAS         = 3'd2,
		REG_STRIDE       = 3'd3,
		REG_ZOOM         = 3'd4,
		REG_FIRST_COPIES = 3'd5,
		REG_PIXEL_COUNT  = 3'd6,
		REG_DEST_LENGTH  = 3'd7
	} cfg_index_t;

	// Configuration register contents.
	typedef struct packed {
		logic        [1:0]  sample_format;
		logic signed [31:0] gain;
		logic signed [31:0] bias;
		logic        [7:0]  stride;
		logic        [4:0]  zoom;
		logic        [4:0]  first_copies;
		logic        [15:0] pixel_count;
		logic        [15:0] dest_length;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic signed [31:0] sample;
		logic               line_start;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] pixel;
		logic       last_copy;
	} out_item_t;

endpackage

`default_nettype wire

// ----- rtl/pscz_front.sv -----
// ----------------------------------------------------------------------------
// pscz_front: line tracking and classification of source elements
// Decimates each line by the stride, decodes the sample format, applies the
// pixel count and byte budget, and queues kept samples with their copy count.
// ----------------------------------------------------------------------------
`default_nettype none

module pscz_front #(
	parameter int MAX_ZOOM  = pscz_pkg::MAX_ZOOM_DEF,
	parameter int LINE_BITS = pscz_pkg::LINE_BITS_DEF,
	parameter int CNT_W     = $clog2(pscz_pkg::MAX_ZOOM_DEF + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pscz_pkg::cfg_t       cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pscz_pkg::in_item_t   in_item,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output logic signed [31:0]        push_sample,
	output logic [CNT_W-1:0]          push_copies
);
	import pscz_pkg::*;

	localparam int CMP_W = (LINE_BITS > 16) ? LINE_BITS : 16;
	localparam int XW    = (CNT_W > 5) ? CNT_W : 5;
	localparam logic [LINE_BITS-1:0] CNT_MAX = '1;

	logic [7:0]           phase_q;
	logic [LINE_BITS-1:0] taken_q;
	logic [LINE_BITS-1:0] budget_q;
	logic                 first_q;

	logic [7:0]           phase_cur, phase_nxt, st;
	logic [8:0]           phase_inc;
	logic [LINE_BITS-1:0] taken_cur, taken_nxt, budget_cur, budget_nxt, dest_sat;
	logic [LINE_BITS-1:0] cz, cut;
	logic                 first_cur, first_nxt;
	logic                 kept, fmt_ok, room, take, accept;
	logic [4:0]           raw_copies;
	logic [XW-1:0]        clamped;

	// The queue's free space alone gates acceptance.
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	// Classification of the offered item against the line state.
	always_comb begin
		phase_cur  = in_item.line_start ? 8'd0 : phase_q;
		taken_cur  = in_item.line_start ? '0 : taken_q;
		first_cur  = in_item.line_start ? 1'b1 : first_q;
		dest_sat   = (CMP_W'(cfg.dest_length) > CMP_W'(CNT_MAX)) ? CNT_MAX
			: LINE_BITS'(cfg.dest_length);
		budget_cur = in_item.line_start ? dest_sat : budget_q;

		st        = (cfg.stride == 8'd0) ? 8'd1 : cfg.stride;
		phase_inc = {1'b0, phase_cur} + 9'd1;
		phase_nxt = (phase_inc >= {1'b0, st}) ? 8'd0 : phase_inc[7:0];
		kept      = (phase_cur == 8'd0);

		fmt_ok = (cfg.sample_format == FMT_U8) || (cfg.sample_format == FMT_S16)
			|| (cfg.sample_format == FMT_S32);
		case (cfg.sample_format)
			FMT_U8:  push_sample = signed'({24'd0, in_item.sample[7:0]});
			FMT_S16: push_sample = signed'({{16{in_item.sample[15]}}, in_item.sample[15:0]});
			default: push_sample = in_item.sample;
		endcase

		room = CMP_W'(taken_cur) < CMP_W'(cfg.pixel_count);
		take = kept && fmt_ok && room;

		// Copy count: first pixel override, zoom limit, then budget cut.
		raw_copies = (first_cur && cfg.first_copies != 5'd0) ? cfg.first_copies : cfg.zoom;
		clamped    = (XW'(raw_copies) > XW'(MAX_ZOOM)) ? XW'(MAX_ZOOM) : XW'(raw_copies);
		cz         = LINE_BITS'(clamped);
		cut        = (cz > budget_cur) ? budget_cur : cz;

		if (take) begin
			first_nxt  = 1'b0;
			taken_nxt  = (taken_cur == CNT_MAX) ? taken_cur : taken_cur + 1'b1;
			budget_nxt = budget_cur - cut;
		end else begin
			first_nxt  = first_cur;
			taken_nxt  = taken_cur;
			budget_nxt = budget_cur;
		end

		push_copies = cut[CNT_W-1:0];
		push_valid  = in_valid && take && (cut != '0);
	end

	// Line state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 8'd0;
			taken_q  <= '0;
			budget_q <= '0;
			first_q  <= 1'b1;
		end else if (accept) begin
			phase_q  <= phase_nxt;
			taken_q  <= taken_nxt;
			budget_q <= budget_nxt;
			first_q  <= first_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pscz_queue.sv -----
// ----------------------------------------------------------------------------
// pscz_queue: short first-in first-out queue
// Decouples the classifying front from the stretching and replicating back.
// ----------------------------------------------------------------------------
`default_nettype none

module pscz_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = pscz_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	import pscz_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pscz_back.sv -----
// ----------------------------------------------------------------------------
// pscz_back: contrast stretch and pixel replication
// Multiplies each queued sample by the gain, adds the bias, clamps to a byte
// and then presents the byte once per copy in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pscz_back #(
	parameter int CNT_W = $clog2(pscz_pkg::MAX_ZOOM_DEF + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pscz_pkg::cfg_t       cfg,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire logic signed [31:0]   pop_sample,
	input  wire logic [CNT_W-1:0]     pop_copies,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pscz_pkg::out_item_t       out_item
);
	import pscz_pkg::*;

	logic               v_s1, v_s2;
	logic signed [63:0] prod_s1;
	logic [CNT_W-1:0]   copies_s1, copies_s2;
	logic [7:0]         pixel_s2;
	logic [7:0]         pix_q;
	logic [CNT_W-1:0]   left_q;
	logic               ready_s1, ready_s2, rep_free;
	logic signed [63:0] sum;
	logic [7:0]         pixel_c;

	// Stage handshakes: each stage moves when the next has room.
	assign rep_free  = !out_valid || (out_ready && left_q == CNT_W'(1));
	assign ready_s2  = !v_s2 || rep_free;
	assign ready_s1  = !v_s1 || ready_s2;
	assign pop_ready = ready_s1;

	// Bias add and clamp to 0..255 with truncation.
	always_comb begin
		sum = prod_s1 + signed'({{32{cfg.bias[31]}}, cfg.bias});
		if (sum[63]) begin
			pixel_c = 8'd0;
		end else if (sum[62:24] != '0) begin
			pixel_c = PIX_MAX;
		end else begin
			pixel_c = sum[23:16];
		end
	end

	// Multiply and clamp stages.
	always_ff @(posedge clk) begin
		if (ready_s1 && pop_valid) begin
			prod_s1   <= pop_sample * cfg.gain;
			copies_s1 <= pop_copies;
		end
		if (ready_s2 && v_s1) begin
			pixel_s2  <= pixel_c;
			copies_s2 <= copies_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= pop_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Replication counter in the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			left_q    <= '0;
			pix_q     <= 8'd0;
		end else begin
			if (out_valid && out_ready) begin
				if (left_q == CNT_W'(1)) begin
					out_valid <= 1'b0;
				end else begin
					left_q <= left_q - 1'b1;
				end
			end
			if (v_s2 && rep_free) begin
				out_valid <= 1'b1;
				pix_q     <= pixel_s2;
				left_q    <= copies_s2;
			end
		end
	end

	assign out_item.pixel     = pix_q;
	assign out_item.last_copy = (left_q == CNT_W'(1));

endmodule

`default_nettype wire

// ----- rtl/pixel_stretch_clamp_zoom.sv -----
// ----------------------------------------------------------------------------
// pixel_stretch_clamp_zoom: linear contrast stretch with replication zoom
// Input channel in_valid/in_ready carries one source element and a line
// start mark per item. Output channel out_valid/out_ready carries display
// bytes, with last_copy set on the final copy caused by one source element.
// Registers must be written via cfg_we/cfg_index/cfg_data only while idle;
// the block does not enforce this. The front accepts one item per cycle
// while its four-entry queue has room. The back multiplies, clamps and
// then emits one byte per cycle while out_ready is high, so a kept pixel
// with N copies fills the output with N bytes; the input stalls once the
// queue fills. Items pass the queue, multiply, clamp and output registers.
// A stalled receiver holds the output register and backs up the stages and
// the queue; the input keeps being taken until the queue is full.
// Reset clears the line state and loads the register defaults; nothing is
// emitted until a line start mark loads the byte budget.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_stretch_clamp_zoom #(
	parameter int MAX_ZOOM  = pscz_pkg::MAX_ZOOM_DEF,
	parameter int LINE_BITS = pscz_pkg::LINE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pscz_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pscz_pkg::out_item_t       out_item
);
	import pscz_pkg::*;

	localparam int CNT_W = $clog2(MAX_ZOOM + 1);
	localparam int Q_W   = 32 + CNT_W;

	cfg_t               cfg_q;
	logic               push_valid, push_ready, pop_valid, pop_ready;
	logic signed [31:0] push_sample;
	logic [CNT_W-1:0]   push_copies;
	logic [Q_W-1:0]     pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format <= FMT_U8;
			cfg_q.gain          <= 32'sd65536;
			cfg_q.bias          <= 32'sd0;
			cfg_q.stride        <= 8'd1;
			cfg_q.zoom          <= 5'd1;
			cfg_q.first_copies  <= 5'd0;
			cfg_q.pixel_count   <= 16'hFFFF;
			cfg_q.dest_length   <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORMAT:       cfg_q.sample_format <= cfg_data[1:0];
				REG_GAIN:         cfg_q.gain          <= signed'(cfg_data);
				REG_BIAS:         cfg_q.bias          <= signed'(cfg_data);
				REG_STRIDE:       cfg_q.stride        <= cfg_data[7:0];
				REG_ZOOM:         cfg_q.zoom          <= cfg_data[4:0];
				REG_FIRST_COPIES: cfg_q.first_copies  <= cfg_data[4:0];
				REG_PIXEL_COUNT:  cfg_q.pixel_count   <= cfg_data[15:0];
				REG_DEST_LENGTH:  cfg_q.dest_length   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	pscz_front #(
		.MAX_ZOOM  (MAX_ZOOM),
		.LINE_BITS (LINE_BITS),
		.CNT_W     (CNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_sample (push_sample),
		.push_copies (push_copies)
	);

	pscz_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_sample, push_copies}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pscz_back #(
		.CNT_W (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_sample (signed'(pop_data[Q_W-1:CNT_W])),
		.pop_copies (pop_data[CNT_W-1:0]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire
